[hw/rtl/jchb_pkg.sv]
// Shared types and constants for the jump consistent hash bucket block.
// Used by jchb_lcg, jchb_div and jump_consistent_hash_bucket. No dependencies.
`default_nettype none

package jchb_pkg;

    localparam int KEY_W    = 64;
    localparam int COUNT_W  = 31;
    localparam int BUCKET_W = 32;
    localparam int DIVS_W   = 32;
    // numerator is (cur+1) << 31, at most 62 bits wide
    localparam int NUM_W    = COUNT_W + COUNT_W;
    localparam int KEY_SHIFT = 33;

    localparam logic [KEY_W-1:0] LCG_MULT = 64'd2862933555777941757;

    localparam int MUL_CNT_W = $clog2(KEY_W);
    localparam int DIV_CNT_W = $clog2(NUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } jchb_state_t;

    typedef struct packed {
        logic               ovf;   // quotient does not fit in COUNT_W bits
        logic [COUNT_W-1:0] quot;
    } jchb_quot_t;

endpackage

`default_nettype wire

[hw/rtl/jchb_lcg.sv]
// Bit-serial 64-bit linear congruential step: key_out = key_in * LCG_MULT + 1 mod 2^64.
// One key bit per cycle. Depends on jchb_pkg.
`default_nettype none

module jchb_lcg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [jchb_pkg::KEY_W-1:0] key_in,
    output logic                            done,
    output logic [jchb_pkg::KEY_W-1:0]      key_out
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [jchb_pkg::MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [jchb_pkg::KEY_W-1:0]       acc_reg, acc_next;
    logic [jchb_pkg::KEY_W-1:0]       mc_reg, mc_next;
    logic [jchb_pkg::KEY_W-1:0]       kb_reg, kb_next;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        kb_next   = kb_reg;
        if (start)
        begin
            // accumulator starts at 1 to fold in the increment
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = {{(jchb_pkg::KEY_W-1){1'b0}}, 1'b1};
            mc_next   = jchb_pkg::LCG_MULT;
            kb_next   = key_in;
        end
        else if (busy_reg)
        begin
            if (kb_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[jchb_pkg::KEY_W-2:0], 1'b0};
            kb_next  = {1'b0, kb_reg[jchb_pkg::KEY_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == jchb_pkg::MUL_CNT_W'(jchb_pkg::KEY_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        kb_reg  <= kb_next;
    end

    assign done    = done_reg;
    assign key_out = acc_reg;

endmodule

`default_nettype wire

[hw/rtl/jchb_div.sv]
// Restoring divider, one quotient bit per cycle: ((num_hi << 31) / dvs).
// Keeps the low 31 quotient bits plus a sticky overflow flag. Depends on jchb_pkg.
`default_nettype none

module jchb_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [jchb_pkg::COUNT_W-1:0] num_hi,
    input  wire logic [jchb_pkg::DIVS_W-1:0]  dvs,
    output logic                              done,
    output jchb_pkg::jchb_quot_t              result
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [jchb_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [jchb_pkg::COUNT_W-1:0]    num_reg, num_next;
    logic [jchb_pkg::DIVS_W-1:0]     dvs_reg, dvs_next;
    logic [jchb_pkg::DIVS_W-1:0]     rem_reg, rem_next;
    jchb_pkg::jchb_quot_t            q_reg, q_next;
    logic [jchb_pkg::DIVS_W:0]       trial;
    logic [jchb_pkg::DIVS_W:0]       diff;
    logic                            qbit;

    always_comb
    begin
        trial = {rem_reg, num_reg[jchb_pkg::COUNT_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        qbit  = ~diff[jchb_pkg::DIVS_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = num_hi;
            dvs_next  = dvs;
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            // remainder stays below dvs <= 2^31, so 32 bits hold it
            rem_next    = qbit ? diff[jchb_pkg::DIVS_W-1:0] : trial[jchb_pkg::DIVS_W-1:0];
            num_next    = {num_reg[jchb_pkg::COUNT_W-2:0], 1'b0};
            q_next.quot = {q_reg.quot[jchb_pkg::COUNT_W-2:0], qbit};
            q_next.ovf  = q_reg.ovf | q_reg.quot[jchb_pkg::COUNT_W-1];
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == jchb_pkg::DIV_CNT_W'(jchb_pkg::NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

`default_nettype wire

[hw/rtl/jump_consistent_hash_bucket.sv]
// Jump consistent hash bucket selector, top level: control FSM, config, output register.
// Instantiates jchb_lcg and jchb_div; depends on jchb_pkg.
// Each request runs P loop passes, P = about ln(count)+1, each pass a serial LCG multiply
//   followed by a serial divide; for count 0 the loop is skipped.
// Throughput: one request at a time; the next is taken as soon as the result is registered.
// Reset: async active low; bucket_count returns to 1, FSM idle, no result pending.
`default_nettype none

module jump_consistent_hash_bucket (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // config: bucket_count in [30:0], bit 31 ignored
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data,
    // s_tdata: key [63:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    // m_tdata: bucket [31:0], signed
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    jchb_pkg::jchb_state_t               state_reg, state_next;
    logic [jchb_pkg::COUNT_W-1:0]        count_reg, count_next;
    logic [jchb_pkg::KEY_W-1:0]          key_reg, key_next;
    logic [jchb_pkg::COUNT_W-1:0]        cur_reg, cur_next;
    logic [jchb_pkg::BUCKET_W-1:0]       res_reg, res_next;
    logic                                out_valid_reg, out_valid_next;
    logic [jchb_pkg::BUCKET_W-1:0]       out_data_reg, out_data_next;

    logic                                s_fire;
    logic                                count_zero;
    logic                                out_free;
    logic                                out_load;
    logic                                stop;
    logic                                lcg_start, lcg_done;
    logic [jchb_pkg::KEY_W-1:0]          lcg_key_in, lcg_key_out;
    logic                                div_start, div_done;
    logic [jchb_pkg::DIVS_W-1:0]         div_dvs;
    logic [jchb_pkg::COUNT_W-1:0]        div_num;
    jchb_pkg::jchb_quot_t                div_res;

    assign cfg_ready  = 1'b1;
    assign s_fire     = s_tvalid && s_tready;
    assign count_zero = (count_reg == '0);
    assign out_free   = !out_valid_reg || m_tready;
    assign stop       = div_res.ovf || (div_res.quot >= count_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            jchb_pkg::ST_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = count_zero ? jchb_pkg::ST_FINISH : jchb_pkg::ST_MUL;
                end
            end
            jchb_pkg::ST_MUL:
            begin
                if (lcg_done)
                begin
                    state_next = jchb_pkg::ST_DIV;
                end
            end
            jchb_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = stop ? jchb_pkg::ST_FINISH : jchb_pkg::ST_MUL;
                end
            end
            jchb_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = jchb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = jchb_pkg::ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = 1'b0;
        lcg_start = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            jchb_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                lcg_start = s_tvalid && !count_zero;
            end
            jchb_pkg::ST_MUL:
            begin
                div_start = lcg_done;
            end
            jchb_pkg::ST_DIV:
            begin
                lcg_start = div_done && !stop;
            end
            jchb_pkg::ST_FINISH:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign lcg_key_in = (state_reg == jchb_pkg::ST_IDLE) ? s_tdata : key_reg;
    // divisor = (key >> 33) + 1, range 1..2^31
    assign div_dvs = {1'b0, lcg_key_out[jchb_pkg::KEY_W-1:jchb_pkg::KEY_SHIFT]} + 1'b1;
    assign div_num = cur_reg + 1'b1;

    // datapath
    always_comb
    begin
        count_next     = count_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready)
        begin
            count_next = cfg_data[jchb_pkg::COUNT_W-1:0];
        end
        if (s_fire)
        begin
            cur_next = '0;
            res_next = '1;
        end
        if (state_reg == jchb_pkg::ST_MUL && lcg_done)
        begin
            key_next = lcg_key_out;
        end
        if (state_reg == jchb_pkg::ST_DIV && div_done)
        begin
            if (stop)
            begin
                res_next = {1'b0, cur_reg};
            end
            else
            begin
                cur_next = div_res.quot;
            end
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= jchb_pkg::ST_IDLE;
            count_reg     <= jchb_pkg::COUNT_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        cur_reg      <= cur_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    jchb_lcg u_lcg (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (lcg_start),
        .key_in  (lcg_key_in),
        .done    (lcg_done),
        .key_out (lcg_key_out)
    );

    jchb_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_hi (div_num),
        .dvs    (div_dvs),
        .done   (div_done),
        .result (div_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire
